[sv/wst_pkg.sv]
package wst_pkg;

    // Field widths
    localparam int MAC_W   = 48;
    localparam int LEN_W   = 12;
    localparam int FC_W    = 8;
    localparam int CHAN_W  = 4;
    localparam int RSSI_W  = 8;
    localparam int TIME_W  = 32;
    localparam int ACT_W   = 3;
    localparam int SLOT_W  = 5;
    localparam int TOTAL_W = 6;

    // Input tdata layout, lowest bit first
    localparam int IN_LEN_LO  = 0;
    localparam int IN_FCL_LO  = IN_LEN_LO + LEN_W;
    localparam int IN_FCH_LO  = IN_FCL_LO + FC_W;
    localparam int IN_A1_LO   = IN_FCH_LO + FC_W;
    localparam int IN_A2_LO   = IN_A1_LO + MAC_W;
    localparam int IN_CHAN_LO = IN_A2_LO + MAC_W;
    localparam int IN_SIG_LO  = IN_CHAN_LO + CHAN_W;
    localparam int IN_NOW_LO  = IN_SIG_LO + RSSI_W;
    localparam int IN_W       = IN_NOW_LO + TIME_W;

    // Output tdata width (116 field bits, padded to 15 bytes)
    localparam int OUT_FIELDS_W = SLOT_W + TOTAL_W + MAC_W + MAC_W + 1 + RSSI_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Result action codes
    localparam logic [ACT_W-1:0] ACT_IGNORED = 3'd0;
    localparam logic [ACT_W-1:0] ACT_UPDATED = 3'd1;
    localparam logic [ACT_W-1:0] ACT_NEW     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FULL    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEARED = 3'd4;

    // Configuration register indexes
    localparam logic CFG_OWN_MAC = 1'b0;
    localparam logic CFG_SCAN_EN = 1'b1;

    // Frame control decode
    localparam logic [1:0]       FT_MGMT       = 2'd0;
    localparam logic [1:0]       FT_DATA       = 2'd2;
    localparam logic [3:0]       SUB_PROBE_REQ = 4'd4;
    localparam logic [1:0]       DS_TO_ONLY    = 2'b01;
    localparam logic [1:0]       DS_FROM_ONLY  = 2'b10;
    localparam logic [LEN_W-1:0] MIN_HDR_LEN   = 12'd24;
    localparam int               GROUP_BIT     = 40;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [MAC_W-1:0]         mac;
        logic [MAC_W-1:0]         bssid;
        logic                     has_bssid;
        logic signed [RSSI_W-1:0] rssi;
        logic [CHAN_W-1:0]        channel;
        logic [TIME_W-1:0]        seen_ms;
        logic                     probing;
    } entry_t;

    // Frame classification from the decoder
    typedef struct packed {
        logic             drop;
        logic [MAC_W-1:0] client;
        logic [MAC_W-1:0] bssid;
        logic             has_bssid;
        logic             probe;
    } cls_t;

    // One result beat
    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [SLOT_W-1:0]        slot;
        logic [TOTAL_W-1:0]       total;
        logic [MAC_W-1:0]         client;
        logic [MAC_W-1:0]         bssid;
        logic                     known;
        logic signed [RSSI_W-1:0] rssi;
    } res_t;

endpackage

[sv/wireless_station_table_unit.sv]
// Client station tracker for 802.11 frame headers.
// Input beats (s_tdata/s_tuser) carry either a frame header or, with
// s_tuser high, a clear command. Each input beat yields exactly one
// result beat on m_tdata/m_tuser, where m_tuser carries the action code.
// The cfg channel writes own_mac (index 0) and scan_enable (index 1);
// cfg_ready is always high and writes belong to idle periods.
// A clear or an ignored frame is settled in the decode state and goes
// straight to the result register. A tracked frame walks the table one
// slot per cycle through a single address comparator fed by the entry
// RAM's registered read port, then passes an update or append state.
// The next beat can be taken the cycle after the output register loads.
// One item is in flight at a time; s_tready is high only while the
// sequencer idles, and it may rise while the previous result still waits.
// If m_tready stays low the finished result is held in the sequencer
// until the output register frees, and no new beat is taken meanwhile.
// Reset clears the station count, the configuration and all handshake
// state; the entry RAM is not cleared, since only slots below the count
// are ever read.
module wireless_station_table_unit import wst_pkg::*; #(
    parameter int STATION_SLOTS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // tdata fields from bit 0: frame_len, fc_low, fc_high, first_address,
    // second_address, rx_channel, signal_dbm, now_ms
    input  logic [IN_W-1:0]    s_tdata,
    // tuser fields: cmd
    input  logic               s_tuser,
    input  logic               s_tvalid,
    output logic               s_tready,
    // tdata fields from bit 0: slot, station_total, client_mac, ap_bssid,
    // bssid_known, peak_rssi, zero padding
    output logic [OUT_W-1:0]   m_tdata,
    // tuser fields: action
    output logic [ACT_W-1:0]   m_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [MAC_W-1:0]   cfg_data
);

    localparam int IDX_W   = (STATION_SLOTS > 1) ? $clog2(STATION_SLOTS) : 1;
    localparam int CNT_W   = $clog2(STATION_SLOTS + 1);
    localparam int ENTRY_W = $bits(entry_t);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(STATION_SLOTS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_APPEND = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [MAC_W-1:0] own_mac_reg;
    logic             scan_en_reg;
    logic             cmd_reg;
    logic [IN_W-1:0]  in_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    entry_t           entry_reg, entry_next;
    res_t             res_reg, res_next;
    res_t             out_reg;
    logic             m_tvalid_reg;

    cls_t             cls;
    logic [MAC_W-1:0] in_a1, in_a2;
    logic signed [RSSI_W-1:0] in_sig;
    logic [TIME_W-1:0] in_now;
    logic [CHAN_W-1:0] in_chan;

    logic               ram_wr_en, ram_rd_en;
    logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
    entry_t             ram_wr_data;
    logic [ENTRY_W-1:0] ram_rd_data;
    entry_t             rd_entry;
    logic               hit;
    logic               out_free;

    // Unpack the held frame header
    assign in_a1   = in_reg[IN_A1_LO +: MAC_W];
    assign in_a2   = in_reg[IN_A2_LO +: MAC_W];
    assign in_chan = in_reg[IN_CHAN_LO +: CHAN_W];
    assign in_sig  = in_reg[IN_SIG_LO +: RSSI_W];
    assign in_now  = in_reg[IN_NOW_LO +: TIME_W];

    wst_classify u_classify (
        .frame_len      (in_reg[IN_LEN_LO +: LEN_W]),
        .fc_low         (in_reg[IN_FCL_LO +: FC_W]),
        .fc_high        (in_reg[IN_FCH_LO +: FC_W]),
        .first_address  (in_a1),
        .second_address (in_a2),
        .own_mac        (own_mac_reg),
        .scan_enable    (scan_en_reg),
        .cls            (cls)
    );

    wst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STATION_SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_entry = ram_rd_data;
    // Shared address comparator: one stored slot per cycle
    assign hit      = pend_reg && (rd_entry.mac == cls.client);
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        hit_idx_next  = hit_idx_reg;
        entry_next    = entry_reg;
        res_next      = res_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = issue_reg[IDX_W-1:0];
        ram_wr_en     = 1'b0;
        ram_wr_addr   = hit_idx_reg;
        ram_wr_data   = entry_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                res_next       = '0;
                res_next.total = TOTAL_W'(count_reg);
                issue_next     = '0;
                if (cmd_reg) begin
                    count_next      = '0;
                    res_next.action = ACT_CLEARED;
                    res_next.total  = '0;
                    state_next      = ST_DONE;
                end else if (cls.drop) begin
                    res_next.action = ACT_IGNORED;
                    state_next      = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Capture a matching entry and stop
                if (hit) begin
                    entry_next   = rd_entry;
                    hit_idx_next = pend_idx_reg;
                    state_next   = ST_UPDATE;
                end else if (issue_reg < count_reg) begin
                    // Issue the next slot read
                    ram_rd_en     = 1'b1;
                    issue_next    = issue_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                end else if (!pend_reg) begin
                    state_next = ST_APPEND;
                end
            end
            ST_UPDATE: begin
                ram_wr_en            = 1'b1;
                ram_wr_addr          = hit_idx_reg;
                ram_wr_data          = entry_reg;
                ram_wr_data.seen_ms  = in_now;
                if (in_sig > entry_reg.rssi) begin
                    ram_wr_data.rssi = in_sig;
                end
                if (cls.has_bssid && !entry_reg.has_bssid) begin
                    ram_wr_data.bssid     = cls.bssid;
                    ram_wr_data.has_bssid = 1'b1;
                end
                res_next.action = ACT_UPDATED;
                res_next.slot   = SLOT_W'(hit_idx_reg);
                res_next.total  = TOTAL_W'(count_reg);
                res_next.client = cls.client;
                res_next.bssid  = ram_wr_data.bssid;
                res_next.known  = ram_wr_data.has_bssid;
                res_next.rssi   = ram_wr_data.rssi;
                state_next      = ST_DONE;
            end
            ST_APPEND: begin
                res_next.client = cls.client;
                if (count_reg < SLOTS_CNT) begin
                    // Append the new station at the end of the table
                    ram_wr_en             = 1'b1;
                    ram_wr_addr           = count_reg[IDX_W-1:0];
                    ram_wr_data.mac       = cls.client;
                    ram_wr_data.bssid     = cls.bssid;
                    ram_wr_data.has_bssid = cls.has_bssid;
                    ram_wr_data.rssi      = in_sig;
                    ram_wr_data.channel   = in_chan;
                    ram_wr_data.seen_ms   = in_now;
                    ram_wr_data.probing   = cls.probe;
                    count_next            = count_reg + CNT_W'(1);
                    res_next.action       = ACT_NEW;
                    res_next.slot         = SLOT_W'(count_reg);
                    res_next.total        = TOTAL_W'(count_next);
                    res_next.bssid        = cls.bssid;
                    res_next.known        = cls.has_bssid;
                    res_next.rssi         = in_sig;
                end else begin
                    res_next.action = ACT_FULL;
                    res_next.slot   = '0;
                    res_next.total  = TOTAL_W'(count_reg);
                    res_next.bssid  = '0;
                    res_next.known  = 1'b0;
                    res_next.rssi   = '0;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            own_mac_reg  <= '0;
            scan_en_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            // Hand the result to the output register, drop it once taken
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_OWN_MAC: own_mac_reg <= cfg_data;
                    CFG_SCAN_EN: scan_en_reg <= cfg_data[0];
                    default:     own_mac_reg <= own_mac_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg  <= s_tdata;
            cmd_reg <= s_tuser;
        end
        issue_reg    <= issue_next;
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        entry_reg    <= entry_next;
        res_reg      <= res_next;
        if (state_reg == ST_DONE && out_free) begin
            out_reg <= res_reg;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = out_reg.action;
    assign m_tdata   = {{(OUT_W - OUT_FIELDS_W){1'b0}}, out_reg.rssi, out_reg.known,
                        out_reg.bssid, out_reg.client, out_reg.total, out_reg.slot};

    // The station count never exceeds the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SLOTS_CNT)
        else $error("station count exceeds table size");

    // A pending read always points at a held slot
    a_pend_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (CNT_W'(pend_idx_reg) < count_reg))
        else $error("slot read beyond station count");

    // A clear command empties the table
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECODE && cmd_reg) |=> (count_reg == '0))
        else $error("clear left stations in table");

    // A new entry result reports a nonempty table, unless the table has 64 or more slots
    a_new_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ACT_NEW) |-> (m_tdata[SLOT_W +: TOTAL_W] != '0
                                              || STATION_SLOTS >= 64))
        else $error("new entry reported with empty table");

endmodule

[sv/wst_ram.sv]
module wst_ram import wst_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/wst_classify.sv]
module wst_classify import wst_pkg::*; (
    input  logic [LEN_W-1:0] frame_len,
    input  logic [FC_W-1:0]  fc_low,
    input  logic [FC_W-1:0]  fc_high,
    input  logic [MAC_W-1:0] first_address,
    input  logic [MAC_W-1:0] second_address,
    input  logic [MAC_W-1:0] own_mac,
    input  logic             scan_enable,
    output cls_t             cls
);

    logic [1:0] ftype;
    logic [3:0] subtype;
    logic [1:0] ds;
    logic       known_kind;

    assign ftype   = fc_low[3:2];
    assign subtype = fc_low[7:4];
    assign ds      = fc_high[1:0];

    // Pick the client and BSSID from the frame kind
    always_comb begin
        known_kind    = 1'b1;
        cls.client    = '0;
        cls.bssid     = '0;
        cls.has_bssid = 1'b0;
        cls.probe     = 1'b0;
        if (ftype == FT_MGMT && subtype == SUB_PROBE_REQ) begin
            cls.client = second_address;
            cls.probe  = 1'b1;
        end else if (ftype == FT_DATA && ds == DS_TO_ONLY) begin
            cls.client    = second_address;
            cls.bssid     = first_address;
            cls.has_bssid = 1'b1;
        end else if (ftype == FT_DATA && ds == DS_FROM_ONLY) begin
            cls.client    = first_address;
            cls.bssid     = second_address;
            cls.has_bssid = 1'b1;
        end else begin
            known_kind = 1'b0;
        end
        // Drop when disabled, short, of an untracked kind, group-addressed or our own address
        cls.drop = !scan_enable || (frame_len < MIN_HDR_LEN) || !known_kind
                   || cls.client[GROUP_BIT] || (cls.client == own_mac);
    end

endmodule

[sim/wireless_station_table_unit_tb.sv]
module wireless_station_table_unit_tb;
    import wst_pkg::*;

    localparam int SLOTS           = 32;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int POOL_SIZE       = 40;
    localparam int PHASE_TARGET    = 173;
    localparam int PRINT_CAP       = 200;

    // Result tdata layout, lowest bit first
    localparam int OT_SLOT_LO   = 0;
    localparam int OT_TOTAL_LO  = OT_SLOT_LO + SLOT_W;
    localparam int OT_CLIENT_LO = OT_TOTAL_LO + TOTAL_W;
    localparam int OT_BSSID_LO  = OT_CLIENT_LO + MAC_W;
    localparam int OT_KNOWN_LO  = OT_BSSID_LO + MAC_W;
    localparam int OT_RSSI_LO   = OT_KNOWN_LO + 1;

    // Frame control bytes for the directed headers
    localparam logic [1:0]      FT_CTRL    = 2'd1;
    localparam logic [1:0]      FT_EXT     = 2'd3;
    localparam logic [3:0]      SUB_BEACON = 4'd8;
    localparam logic [3:0]      SUB_RTS    = 4'd11;
    localparam logic [FC_W-1:0] FC_PROBE   = {SUB_PROBE_REQ, FT_MGMT, 2'b00};
    localparam logic [FC_W-1:0] FC_DATA    = {4'd0, FT_DATA, 2'b00};
    localparam logic [FC_W-1:0] FC_BEACON  = {SUB_BEACON, FT_MGMT, 2'b00};
    localparam logic [FC_W-1:0] FC_RTS     = {SUB_RTS, FT_CTRL, 2'b00};
    localparam logic [FC_W-1:0] FC_EXT_SUB = {SUB_PROBE_REQ, FT_EXT, 2'b00};
    localparam logic [FC_W-1:0] FCH_NONE   = '0;
    localparam logic [FC_W-1:0] FCH_TO     = {6'd0, DS_TO_ONLY};
    localparam logic [FC_W-1:0] FCH_FROM   = {6'd0, DS_FROM_ONLY};
    localparam logic [FC_W-1:0] FCH_WDS    = {6'd0, DS_TO_ONLY | DS_FROM_ONLY};

    // Directed addresses
    localparam logic [MAC_W-1:0] STA_A    = 48'h00_1a_2b_3c_4d_5e;
    localparam logic [MAC_W-1:0] STA_B    = 48'hac_de_48_00_11_22;
    localparam logic [MAC_W-1:0] STA_C    = 48'hfe_ff_ff_ff_ff_fe;
    localparam logic [MAC_W-1:0] STA_D    = 48'h02_00_00_00_00_00;
    localparam logic [MAC_W-1:0] AP_ONE   = 48'h00_11_22_33_44_55;
    localparam logic [MAC_W-1:0] AP_TWO   = 48'h66_77_88_99_aa_bb;
    localparam logic [MAC_W-1:0] OWN_AP   = 48'h0a_0b_0c_0d_0e_0f;
    localparam logic [MAC_W-1:0] MCAST    = 48'h01_00_5e_00_00_fb;
    localparam logic [MAC_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic                     cmd;
        logic [LEN_W-1:0]         len;
        logic [FC_W-1:0]          fcl;
        logic [FC_W-1:0]          fch;
        logic [MAC_W-1:0]         a1;
        logic [MAC_W-1:0]         a2;
        logic [CHAN_W-1:0]        chan;
        logic signed [RSSI_W-1:0] sig;
        logic [TIME_W-1:0]        now;
    } frame_hdr_t;

    // Station table tracker: predicts each result and checks the result beats
    class station_tracker_scoreboard;
        logic [MAC_W-1:0]         own_mac;
        logic                     scan_en;
        logic [MAC_W-1:0]         mac_tab [SLOTS];
        logic [MAC_W-1:0]         bssid_tab [SLOTS];
        logic                     known_tab [SLOTS];
        logic signed [RSSI_W-1:0] peak_tab [SLOTS];
        int unsigned              station_cnt;
        res_t                     pending_results [$];
        int unsigned              mismatches;

        function new();
            own_mac     = '0;
            scan_en     = 1'b0;
            station_cnt = 0;
            mismatches  = 0;
        endfunction

        function void note_config(logic idx, logic [MAC_W-1:0] data);
            if (idx == CFG_OWN_MAC) begin
                own_mac = data;
            end else begin
                scan_en = data[0];
            end
        endfunction

        // Apply one accepted beat to the table and queue the result it must give
        function logic [ACT_W-1:0] predict_station_update(frame_hdr_t h);
            res_t             r;
            logic [MAC_W-1:0] client;
            logic [MAC_W-1:0] bssid;
            logic             has_bssid;
            logic             tracked;
            int               hit;
            r         = '0;
            client    = '0;
            bssid     = '0;
            has_bssid = 1'b0;
            tracked   = 1'b0;
            hit       = -1;
            r.action  = ACT_IGNORED;
            if (h.cmd) begin
                station_cnt = 0;
                r.action    = ACT_CLEARED;
            end else if (scan_en && h.len >= MIN_HDR_LEN) begin
                // classify: probe request, or data with exactly one DS bit
                if (h.fcl[3:2] == FT_MGMT && h.fcl[7:4] == SUB_PROBE_REQ) begin
                    client  = h.a2;
                    tracked = 1'b1;
                end else if (h.fcl[3:2] == FT_DATA && h.fch[1:0] == DS_TO_ONLY) begin
                    client    = h.a2;
                    bssid     = h.a1;
                    has_bssid = 1'b1;
                    tracked   = 1'b1;
                end else if (h.fcl[3:2] == FT_DATA && h.fch[1:0] == DS_FROM_ONLY) begin
                    client    = h.a1;
                    bssid     = h.a2;
                    has_bssid = 1'b1;
                    tracked   = 1'b1;
                end
            end
            if (tracked && !client[GROUP_BIT] && client != own_mac) begin
                r.client = client;
                for (int i = 0; i < int'(station_cnt); i++) begin
                    if (hit < 0 && mac_tab[i] == client) hit = i;
                end
                if (hit >= 0) begin
                    // known station: keep the peak, take a first BSSID
                    if ($signed(h.sig) > $signed(peak_tab[hit])) peak_tab[hit] = h.sig;
                    if (has_bssid && !known_tab[hit]) begin
                        bssid_tab[hit] = bssid;
                        known_tab[hit] = 1'b1;
                    end
                    r.action = ACT_UPDATED;
                end else if (station_cnt < SLOTS) begin
                    hit            = int'(station_cnt);
                    mac_tab[hit]   = client;
                    bssid_tab[hit] = bssid;
                    known_tab[hit] = has_bssid;
                    peak_tab[hit]  = h.sig;
                    station_cnt++;
                    r.action = ACT_NEW;
                end else begin
                    r.action = ACT_FULL;
                end
                if (r.action == ACT_UPDATED || r.action == ACT_NEW) begin
                    r.slot  = hit[SLOT_W-1:0];
                    r.bssid = bssid_tab[hit];
                    r.known = known_tab[hit];
                    r.rssi  = peak_tab[hit];
                end
            end
            r.total = station_cnt[TOTAL_W-1:0];
            pending_results.push_back(r);
            return r.action;
        endfunction

        task report_mismatch(string what, logic [MAC_W-1:0] got, logic [MAC_W-1:0] want);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
        endtask

        // Compare one result beat with the oldest queued prediction
        task check_result(logic [ACT_W-1:0] act, logic [OUT_W-1:0] data);
            res_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", MAC_W'(act), '0);
            end else begin
                want = pending_results.pop_front();
                if (act !== want.action)
                    report_mismatch("action", MAC_W'(act), MAC_W'(want.action));
                if (data[OT_SLOT_LO +: SLOT_W] !== want.slot)
                    report_mismatch("slot", MAC_W'(data[OT_SLOT_LO +: SLOT_W]),
                                    MAC_W'(want.slot));
                if (data[OT_TOTAL_LO +: TOTAL_W] !== want.total)
                    report_mismatch("station_total", MAC_W'(data[OT_TOTAL_LO +: TOTAL_W]),
                                    MAC_W'(want.total));
                if (data[OT_CLIENT_LO +: MAC_W] !== want.client)
                    report_mismatch("client_mac", data[OT_CLIENT_LO +: MAC_W], want.client);
                if (data[OT_BSSID_LO +: MAC_W] !== want.bssid)
                    report_mismatch("ap_bssid", data[OT_BSSID_LO +: MAC_W], want.bssid);
                if (data[OT_KNOWN_LO] !== want.known)
                    report_mismatch("bssid_known", MAC_W'(data[OT_KNOWN_LO]),
                                    MAC_W'(want.known));
                if (data[OT_RSSI_LO +: RSSI_W] !== want.rssi)
                    report_mismatch("peak_rssi", MAC_W'(data[OT_RSSI_LO +: RSSI_W]),
                                    MAC_W'(want.rssi));
            end
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic [IN_W-1:0]    s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic [ACT_W-1:0]   m_tuser;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [MAC_W-1:0]   cfg_data = '0;

    station_tracker_scoreboard sb;
    logic [MAC_W-1:0]          client_pool [POOL_SIZE];
    logic [MAC_W-1:0]          ap_pool [4];
    int                        tx_idle_pct = 0;
    int                        rx_idle_pct = 0;
    bit                        rx_hold_req = 1'b0;
    int                        hold_left = 0;
    int                        stall_cycles = 0;

    wireless_station_table_unit #(
        .STATION_SLOTS (SLOTS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[MAC_W-1:0];
    endfunction

    function automatic frame_hdr_t make_frame(input logic [FC_W-1:0] fcl,
                                              input logic [FC_W-1:0] fch,
                                              input logic [MAC_W-1:0] a1,
                                              input logic [MAC_W-1:0] a2,
                                              input logic [LEN_W-1:0] len,
                                              input logic signed [RSSI_W-1:0] sig);
        frame_hdr_t h;
        h.cmd  = 1'b0;
        h.len  = len;
        h.fcl  = fcl;
        h.fch  = fch;
        h.a1   = a1;
        h.a2   = a2;
        h.chan = CHAN_W'($urandom);
        h.sig  = sig;
        h.now  = $urandom;
        return h;
    endfunction

    // Mostly well-formed station frames from a small address pool, rare clears, some noise
    function automatic frame_hdr_t random_frame();
        frame_hdr_t       h;
        logic [MAC_W-1:0] client;
        logic [MAC_W-1:0] bssid;
        int unsigned      pick;
        h      = make_frame(FC_W'($urandom), FC_W'($urandom), rand_mac(), rand_mac(),
                            LEN_W'($urandom_range(MIN_HDR_LEN, 4095)), RSSI_W'($urandom));
        pick   = $urandom_range(199);
        client = ($urandom_range(9) == 0) ? rand_mac() : client_pool[$urandom_range(POOL_SIZE-1)];
        bssid  = ($urandom_range(3) == 0) ? rand_mac() : ap_pool[$urandom_range(3)];
        if (pick == 0) begin
            h.cmd = 1'b1;
        end else if (pick < 160) begin
            case ($urandom_range(2))
                0: begin
                    h.fcl = {SUB_PROBE_REQ, FT_MGMT, h.fcl[1:0]};
                    h.a2  = client;
                end
                1: begin
                    h.fcl = {h.fcl[7:4], FT_DATA, h.fcl[1:0]};
                    h.fch = {h.fch[7:2], DS_TO_ONLY};
                    h.a1  = bssid;
                    h.a2  = client;
                end
                default: begin
                    h.fcl = {h.fcl[7:4], FT_DATA, h.fcl[1:0]};
                    h.fch = {h.fch[7:2], DS_FROM_ONLY};
                    h.a1  = client;
                    h.a2  = bssid;
                end
            endcase
        end else if ($urandom_range(1) == 0) begin
            h.len = LEN_W'($urandom_range(0, 40));
            h.a2  = client;
        end else begin
            h.len = LEN_W'($urandom);
        end
        return h;
    endfunction

    // Offer one beat after a random gap; predict at the accepting edge
    task automatic send_item(input frame_hdr_t h, output logic [ACT_W-1:0] act);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= h.cmd;
        s_tdata  <= {h.now, h.sig, h.chan, h.a2, h.a1, h.fch, h.fcl, h.len};
        do @(posedge aclk); while (!s_tready);
        act = sb.predict_station_update(h);
    endtask

    // Write both registers back to back
    task automatic write_config(input logic [MAC_W-1:0] own, input logic scan);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_OWN_MAC;
        cfg_data  <= own;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_config(CFG_OWN_MAC, own);
        cfg_index <= CFG_SCAN_EN;
        cfg_data  <= MAC_W'(scan);
        do @(posedge aclk); while (!cfg_ready);
        sb.note_config(CFG_SCAN_EN, MAC_W'(scan));
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every predicted result, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random_phase(input int tx_pct, input int rx_pct);
        logic [ACT_W-1:0] act;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (PHASE_TARGET) send_item(random_frame(), act);
        drain();
    endtask

    // Result side: check accepted beats, stall at random, honor a long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("wireless_station_table_unit regression: fail");
            $finish;
        end
    end

    initial begin
        frame_hdr_t       h;
        logic [ACT_W-1:0] act;
        sb = new();
        for (int i = 0; i < POOL_SIZE; i++) begin
            client_pool[i]            = rand_mac();
            client_pool[i][GROUP_BIT] = 1'b0;
        end
        for (int i = 0; i < 4; i++) ap_pool[i] = rand_mac();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 26;
        rx_idle_pct = 85;

        // Scanner still off after reset: frames ignored, clear still works
        send_item(make_frame(FC_PROBE, FCH_NONE, ALL_ONES, STA_A, 12'd100, -8'sd60), act);
        h     = random_frame();
        h.cmd = 1'b1;
        send_item(h, act);
        drain();
        write_config(OWN_AP, 1'b1);

        // New stations, shortest header, too short a header
        send_item(make_frame(FC_PROBE, FCH_NONE, ALL_ONES, STA_A, MIN_HDR_LEN, -8'sd60), act);
        send_item(make_frame(FC_PROBE, FCH_NONE, ALL_ONES, STA_A, MIN_HDR_LEN - 12'd1,
                             8'sd10), act);
        send_item(make_frame(FC_DATA, FCH_TO, AP_ONE, STA_B, 12'd60, 8'h80), act);
        h      = make_frame(FC_DATA, FCH_FROM, STA_C, AP_TWO, '1, 8'sd127);
        h.chan = '1;
        h.now  = '1;
        send_item(h, act);
        // Updates: stronger signal, first BSSID taken, later BSSID kept, weaker kept out
        send_item(make_frame(FC_PROBE, FCH_NONE, ALL_ONES, STA_A, 12'd80, -8'sd40), act);
        send_item(make_frame(FC_DATA, FCH_TO, AP_ONE, STA_A, 12'd90, -8'sd90), act);
        send_item(make_frame(FC_DATA, FCH_FROM, STA_A, AP_TWO, 12'd90, -8'sd41), act);
        send_item(make_frame(FC_DATA, FCH_TO, AP_TWO, STA_B, 12'd70, -8'sd127), act);
        // Group, broadcast and own addresses as the client
        send_item(make_frame(FC_PROBE, FCH_NONE, ALL_ONES, ALL_ONES, 12'd64, -8'sd50), act);
        send_item(make_frame(FC_PROBE, FCH_NONE, ALL_ONES, MCAST, 12'd64, -8'sd50), act);
        send_item(make_frame(FC_DATA, FCH_FROM, OWN_AP, AP_ONE, 12'd64, -8'sd50), act);
        // Frames that name no client, then a zero-length header
        send_item(make_frame(FC_DATA, FCH_WDS, AP_ONE, STA_D, 12'd64, -8'sd50), act);
        send_item(make_frame(FC_DATA, FCH_NONE, AP_ONE, STA_D, 12'd64, -8'sd50), act);
        send_item(make_frame(FC_BEACON, FCH_NONE, ALL_ONES, STA_D, 12'd64, -8'sd50), act);
        send_item(make_frame(FC_RTS, FCH_NONE, AP_ONE, STA_D, 12'd64, -8'sd50), act);
        send_item(make_frame(FC_EXT_SUB, FCH_TO, AP_ONE, STA_D, 12'd64, -8'sd50), act);
        send_item(make_frame(FC_DATA, FCH_FROM, STA_D, AP_ONE, 12'd0, -8'sd50), act);
        // Clear with stations held, then refill slot zero
        h     = random_frame();
        h.cmd = 1'b1;
        send_item(h, act);
        h      = make_frame(FC_PROBE, FCH_NONE, ALL_ONES, STA_D, 12'd30, 8'h80);
        h.chan = '0;
        h.now  = '0;
        send_item(h, act);
        drain();

        write_config('0, 1'b1);
        run_random_phase(26, 85);

        write_config(ALL_ONES, 1'b1);
        run_random_phase(85, 26);

        // Scanner off for a short stretch
        write_config(client_pool[3], 1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (10) send_item(random_frame(), act);
        drain();

        // No idling, with one long result hold-off at the start to back up the input
        write_config(client_pool[3], 1'b1);
        rx_hold_req = 1'b1;
        run_random_phase(0, 0);

        if (sb.pending_results.size() != 0)
            sb.report_mismatch("missing result beats", MAC_W'(sb.pending_results.size()), '0);
        if (sb.mismatches == 0) begin
            $display("wireless_station_table_unit regression: pass");
        end else begin
            $display("wireless_station_table_unit regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/wst_pkg.sv
sv/wst_ram.sv
sv/wst_classify.sv
sv/wireless_station_table_unit.sv
sim/wireless_station_table_unit_tb.sv
